@@ rtl/dsgcs_pkg.sv @@
// Shared types and constants for the DMA scatter-gather chunk sequencer.
// Holds request/result payloads, command and status codes, and the
// controller/datapath handshake structs. No dependencies.
`default_nettype none

package dsgcs_pkg;

	localparam int MaxEntries = 16;
	localparam int CountBits  = 24;
	localparam int AddrBits   = 32;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 32;

	// Request commands
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_CHUNK = 2'd2
	} cmd_e;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_PROGRAMMED = 3'd1,
		ST_FINISHED   = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_ZERO_LEN   = 3'd4,
		ST_BAD_MODE   = 3'd5,
		ST_INACTIVE   = 3'd6,
		ST_FULL       = 3'd7
	} status_e;

	// Configuration register indexes
	typedef enum logic [CfgIdxBits-1:0] {
		CFG_MODE     = 2'd0,
		CFG_DEV_ADDR = 2'd1,
		CFG_CLAIMED  = 2'd2
	} cfg_reg_e;

	// Valid transfer modes
	typedef enum logic [1:0] {
		MODE_DEV_TO_MEM = 2'd0,
		MODE_MEM_TO_DEV = 2'd1
	} mode_e;

	typedef struct packed {
		logic [1:0]           command;
		logic [AddrBits-1:0]  entry_address;
		logic [CountBits-1:0] entry_length;
		logic [CountBits-1:0] done_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [AddrBits-1:0]  source_address;
		logic [AddrBits-1:0]  dest_address;
		logic [CountBits-1:0] chunk_count;
	} out_item_t;

	// One table entry
	typedef struct packed {
		logic [AddrBits-1:0]  addr;
		logic [CountBits-1:0] len;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic mem_read;
		logic eval_first;
		logic eval_second;
		logic push;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic advance;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

@@ rtl/dsgcs_ctrl.sv @@
// Controller state machine of the chunk sequencer.
// Sequences capture, table reads, evaluation and result push.
// Depends on dsgcs_pkg.
`default_nettype none

module dsgcs_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output dsgcs_pkg::ctrl_cmd_t        cmd,
	input  wire dsgcs_pkg::dp_status_t  sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_EVAL  = 6'b000100,
		S_READ2 = 6'b001000,
		S_EVAL2 = 6'b010000,
		S_PUSH  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Drive datapath strobes
	always_comb begin
		cmd.capture     = in_valid && in_ready;
		cmd.mem_read    = (state_q == S_READ) || (state_q == S_READ2);
		cmd.eval_first  = (state_q == S_EVAL);
		cmd.eval_second = (state_q == S_EVAL2);
		cmd.push        = (state_q == S_PUSH) && sts.out_free;
	end

	// Advance through the request steps
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ:  state_d = S_EVAL;
			S_EVAL: begin
				state_d = sts.advance ? S_READ2 : S_PUSH;
			end
			S_READ2: state_d = S_EVAL2;
			S_EVAL2: state_d = S_PUSH;
			S_PUSH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dsgcs_dp.sv @@
// Datapath of the chunk sequencer: entry table, walker state, programmed
// registers, configuration registers and the result register.
// Depends on dsgcs_pkg; driven by dsgcs_ctrl strobes.
`default_nettype none

module dsgcs_dp #(
	parameter int MAX_ENTRIES = dsgcs_pkg::MaxEntries
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dsgcs_pkg::ctrl_cmd_t                cmd,
	output dsgcs_pkg::dp_status_t                    sts,
	input  wire dsgcs_pkg::in_item_t                 in_data,
	input  wire logic                                cfg_we,
	input  wire logic [dsgcs_pkg::CfgIdxBits-1:0]    cfg_index,
	input  wire logic [dsgcs_pkg::CfgDataBits-1:0]   cfg_data,
	output dsgcs_pkg::out_item_t                     out_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);

	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CntW = $clog2(MAX_ENTRIES + 1);
	localparam int CB   = dsgcs_pkg::CountBits;
	localparam int AW   = dsgcs_pkg::AddrBits;
	localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

	// Entry table
	dsgcs_pkg::entry_t mem [MAX_ENTRIES];
	dsgcs_pkg::entry_t rd_q;

	// Captured request
	logic [1:0]    cmd_q;
	logic [AW-1:0] req_addr_q;
	logic [CB-1:0] req_len_q;
	logic [CB:0]   sum_q;

	// Walker state
	logic [CntW-1:0] loaded_q;
	logic [CntW-1:0] left_q;
	logic [IdxW-1:0] cur_q;
	logic [CB:0]     off_q;
	logic            active_q;
	logic [AW-1:0]   src_q;
	logic [AW-1:0]   dst_q;
	logic [CB-1:0]   count_q;
	dsgcs_pkg::status_e status_q;

	// Configuration
	logic [1:0]    mode_q;
	logic [AW-1:0] dev_q;
	logic          claim_q;

	// Result register
	dsgcs_pkg::out_item_t out_q;
	logic                 out_valid_q;

	logic [IdxW-1:0] rd_idx;
	logic [IdxW-1:0] wr_idx;
	logic [CntW-1:0] cur_inc;
	logic [IdxW-1:0] next_cur;
	logic            reach;
	logic            more;
	logic            chunk_ok;
	logic            load_ok;
	logic            mode_ok;
	logic            to_mem;
	logic [AW-1:0]   prog_addr;
	logic [CB-1:0]   rest;

	// Walker decisions
	always_comb begin
		rd_idx    = (cmd_q == dsgcs_pkg::CMD_START) ? '0 : cur_q;
		wr_idx    = loaded_q[IdxW-1:0];
		cur_inc   = CntW'(cur_q) + CntW'(1);
		next_cur  = (cur_inc < MaxCnt) ? cur_inc[IdxW-1:0] : '0;
		reach     = sum_q >= {1'b0, rd_q.len};
		more      = left_q > CntW'(1);
		chunk_ok  = claim_q && active_q;
		load_ok   = !active_q && (loaded_q < MaxCnt);
		to_mem    = (mode_q == dsgcs_pkg::MODE_DEV_TO_MEM);
		mode_ok   = to_mem || (mode_q == dsgcs_pkg::MODE_MEM_TO_DEV);
		prog_addr = rd_q.addr + AW'(sum_q);
		rest      = rd_q.len - sum_q[CB-1:0];
	end

	always_comb begin
		sts.advance  = (cmd_q == dsgcs_pkg::CMD_CHUNK) && chunk_ok && reach && more;
		sts.out_free = !out_valid_q || out_ready;
	end

	// Table read and write
	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			rd_q <= mem[rd_idx];
		end
		if (cmd.eval_first && (cmd_q == dsgcs_pkg::CMD_LOAD) && load_ok) begin
			mem[wr_idx] <= '{addr: req_addr_q, len: req_len_q};
		end
	end

	// Hold the accepted request; fold done bytes into the offset early
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q      <= in_data.command;
			req_addr_q <= in_data.entry_address;
			req_len_q  <= in_data.entry_length;
			sum_q      <= off_q + {1'b0, in_data.done_count};
		end
	end

	// Walker state, programmed registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			left_q   <= '0;
			cur_q    <= '0;
			off_q    <= '0;
			active_q <= 1'b0;
			src_q    <= '0;
			dst_q    <= '0;
			count_q  <= '0;
			status_q <= dsgcs_pkg::ST_ACCEPTED;
			mode_q   <= '0;
			dev_q    <= '0;
			claim_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dsgcs_pkg::CFG_MODE:     mode_q  <= cfg_data[1:0];
					dsgcs_pkg::CFG_DEV_ADDR: dev_q   <= cfg_data;
					dsgcs_pkg::CFG_CLAIMED:  claim_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (cmd.eval_first) begin
				unique case (cmd_q)
					dsgcs_pkg::CMD_LOAD: begin
						if (load_ok) begin
							loaded_q <= loaded_q + CntW'(1);
							status_q <= dsgcs_pkg::ST_ACCEPTED;
						end else begin
							status_q <= dsgcs_pkg::ST_FULL;
						end
					end
					dsgcs_pkg::CMD_START: begin
						// Start always consumes the table
						active_q <= 1'b0;
						loaded_q <= '0;
						if (loaded_q == '0) begin
							status_q <= dsgcs_pkg::ST_EMPTY;
						end else if (rd_q.len == '0) begin
							status_q <= dsgcs_pkg::ST_ZERO_LEN;
						end else if (!mode_ok) begin
							status_q <= dsgcs_pkg::ST_BAD_MODE;
						end else begin
							// Device side is written even if the channel is not claimed
							if (to_mem) src_q <= dev_q;
							else        dst_q <= dev_q;
							if (!claim_q) begin
								status_q <= dsgcs_pkg::ST_INACTIVE;
							end else begin
								cur_q    <= '0;
								left_q   <= loaded_q;
								off_q    <= '0;
								active_q <= 1'b1;
								if (to_mem) dst_q <= rd_q.addr;
								else        src_q <= rd_q.addr;
								count_q  <= rd_q.len;
								status_q <= dsgcs_pkg::ST_PROGRAMMED;
							end
						end
					end
					dsgcs_pkg::CMD_CHUNK: begin
						if (!chunk_ok) begin
							status_q <= dsgcs_pkg::ST_INACTIVE;
						end else if (reach) begin
							if (more) begin
								// Step to the next entry; it is programmed after its read
								left_q <= left_q - CntW'(1);
								off_q  <= '0;
								cur_q  <= next_cur;
							end else begin
								active_q <= 1'b0;
								count_q  <= '0;
								status_q <= dsgcs_pkg::ST_FINISHED;
							end
						end else begin
							// Reprogram the rest of the current entry
							off_q <= sum_q;
							if (to_mem) dst_q <= prog_addr;
							else        src_q <= prog_addr;
							count_q  <= rest;
							status_q <= dsgcs_pkg::ST_PROGRAMMED;
						end
					end
					default: begin
						status_q <= dsgcs_pkg::ST_INACTIVE;
					end
				endcase
			end

			// Program the entry just stepped onto
			if (cmd.eval_second) begin
				if (to_mem) dst_q <= rd_q.addr;
				else        src_q <= rd_q.addr;
				count_q <= rd_q.len;
				if (rd_q.len == '0) begin
					active_q <= 1'b0;
					status_q <= dsgcs_pkg::ST_FINISHED;
				end else begin
					status_q <= dsgcs_pkg::ST_PROGRAMMED;
				end
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.status         <= status_q;
			out_q.source_address <= src_q;
			out_q.dest_address   <= dst_q;
			out_q.chunk_count    <= count_q;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/dma_scatter_gather_chunk_sequencer.sv @@
// Top level of the DMA scatter-gather chunk sequencer.
// Instantiates dsgcs_ctrl and dsgcs_dp; types from dsgcs_pkg.
//
//  Channel | Signals                              | Direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, in_data          | request in
//  out     | out_valid, out_ready, out_data       | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write in
//
// A request passes accept, table read, evaluate and push; a chunk completion that
// steps to the next entry adds a second table read and evaluate. The entry table
// has a single registered read port, so each entry is read in a step of its own.
// Reset clears all walker state and configuration; the table holds no reset value.
// A stalled result holds in the output register; the next request is accepted and
// waits in push.
`default_nettype none

module dma_scatter_gather_chunk_sequencer #(
	parameter int MAX_ENTRIES = dsgcs_pkg::MaxEntries
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire dsgcs_pkg::in_item_t                 in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output dsgcs_pkg::out_item_t                     out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dsgcs_pkg::CfgIdxBits-1:0]    cfg_index,
	input  wire logic [dsgcs_pkg::CfgDataBits-1:0]   cfg_data
);

	dsgcs_pkg::ctrl_cmd_t  cmd;
	dsgcs_pkg::dp_status_t sts;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	dsgcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dsgcs_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire

@@ rtl/dsgcs_checker.sv @@
// Port-level checks for the DMA scatter-gather chunk sequencer.
// Bound to dma_scatter_gather_chunk_sequencer; types from dsgcs_pkg.
`default_nettype none

module dsgcs_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire dsgcs_pkg::out_item_t out_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One request in flight: ready drops after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	// A new result only comes out of a request in flight
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");

	// Finished list reports a zero count
	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == dsgcs_pkg::ST_FINISHED) |-> out_data.chunk_count == '0)
		else $error("finished list with nonzero count");

	// Programmed chunk always has bytes to move
	a_programmed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == dsgcs_pkg::ST_PROGRAMMED)
		|-> out_data.chunk_count != '0)
		else $error("programmed chunk with zero count");

endmodule

bind dma_scatter_gather_chunk_sequencer dsgcs_checker u_dsgcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

@@ verif/dma_scatter_gather_chunk_sequencer_tb.sv @@
// Self-checking bench for the scatter-gather chunk sequencer: loads, starts and
// chunk completions go in, every result is compared against an in-bench walker.
// Depends on dsgcs_pkg and the dma_scatter_gather_chunk_sequencer top level.
`default_nettype none

module dma_scatter_gather_chunk_sequencer_tb;

	import dsgcs_pkg::*;

	localparam int unsigned ItemsPerPhase = 420;
	localparam int unsigned SettleCycles  = 12;
	localparam int unsigned QuietLimit    = 3000;
	localparam int unsigned LongHold      = 80;
	localparam logic [CfgIdxBits-1:0] CfgSpare = 2'd3;

	// Tracks the walker state and queues the result each request should produce.
	class sg_walk_tracker;
		logic [AddrBits-1:0]  tbl_addr [MaxEntries];
		logic [CountBits-1:0] tbl_len  [MaxEntries];
		int unsigned n_loaded;
		int unsigned cur_idx;
		int unsigned n_left;
		logic [CountBits:0] offset;
		bit walking;
		logic [AddrBits-1:0]  src_q;
		logic [AddrBits-1:0]  dst_q;
		logic [CountBits-1:0] cnt_q;
		logic [1:0]           mode;
		logic [AddrBits-1:0]  periph_addr;
		bit claimed;
		out_item_t pending_results [$];
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned status_hits [8];

		function new();
			for (int i = 0; i < MaxEntries; i++) begin
				tbl_addr[i] = '0;
				tbl_len[i]  = '0;
			end
			n_loaded = 0;
			cur_idx = 0;
			n_left = 0;
			offset = '0;
			walking = 0;
			src_q = '0;
			dst_q = '0;
			cnt_q = '0;
			mode = MODE_DEV_TO_MEM;
			periph_addr = '0;
			claimed = 0;
			mismatches = 0;
			results_seen = 0;
			for (int i = 0; i < 8; i++)
				status_hits[i] = 0;
		endfunction

		function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
			case (idx)
				CFG_MODE:     mode = data[1:0];
				CFG_DEV_ADDR: periph_addr = data;
				CFG_CLAIMED:  claimed = data[0];
				default: ;
			endcase
		endfunction

		// Program the memory side with what is left of the current entry.
		function logic [CountBits-1:0] program_entry();
			logic [AddrBits-1:0] addr;
			logic [CountBits:0] len_w;
			logic [CountBits:0] rest;
			len_w = {1'b0, tbl_len[cur_idx]};
			rest = (len_w >= offset) ? len_w - offset : '0;
			addr = tbl_addr[cur_idx] + AddrBits'(offset);
			if (mode == MODE_DEV_TO_MEM)
				dst_q = addr;
			else
				src_q = addr;
			cnt_q = rest[CountBits-1:0];
			return cnt_q;
		endfunction

		// A start always consumes the table, then checks it in a fixed order.
		function status_e start_list();
			int unsigned n;
			n = n_loaded;
			walking = 0;
			n_loaded = 0;
			if (n == 0)
				return ST_EMPTY;
			if (tbl_len[0] == '0)
				return ST_ZERO_LEN;
			if (mode == MODE_DEV_TO_MEM)
				src_q = periph_addr;
			else if (mode == MODE_MEM_TO_DEV)
				dst_q = periph_addr;
			else
				return ST_BAD_MODE;
			// device side is already written when the channel is not claimed
			if (!claimed)
				return ST_INACTIVE;
			cur_idx = 0;
			n_left = n;
			offset = '0;
			walking = 1;
			void'(program_entry());
			return ST_PROGRAMMED;
		endfunction

		// Advance the offset; step to the next entry or finish the list.
		function status_e chunk_done(logic [CountBits-1:0] done);
			if (!claimed || !walking)
				return ST_INACTIVE;
			offset = offset + (CountBits+1)'(done);
			if (offset >= {1'b0, tbl_len[cur_idx]}) begin
				if (n_left > 1) begin
					n_left--;
					offset = '0;
					cur_idx = (cur_idx + 1 < MaxEntries) ? cur_idx + 1 : 0;
				end else begin
					walking = 0;
					cnt_q = '0;
					return ST_FINISHED;
				end
			end
			// a zero-length entry programs its address and ends the list
			if (program_entry() == '0) begin
				walking = 0;
				return ST_FINISHED;
			end
			return ST_PROGRAMMED;
		endfunction

		function void note_request(in_item_t req);
			status_e st;
			out_item_t res;
			case (req.command)
				CMD_LOAD: begin
					if (walking || n_loaded >= MaxEntries) begin
						st = ST_FULL;
					end else begin
						tbl_addr[n_loaded] = req.entry_address;
						tbl_len[n_loaded]  = req.entry_length;
						n_loaded++;
						st = ST_ACCEPTED;
					end
				end
				CMD_START: st = start_list();
				CMD_CHUNK: st = chunk_done(req.done_count);
				default:   st = ST_INACTIVE;
			endcase
			res.status = st;
			res.source_address = src_q;
			res.dest_address = dst_q;
			res.chunk_count = cnt_q;
			pending_results.push_back(res);
		endfunction

		function void report_field(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			$display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
				$time, results_seen, field, want, got);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report_field("unrequested result, status", '0, 32'(got.status));
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			status_hits[want.status]++;
			if (got.status !== want.status)
				report_field("status", 32'(want.status), 32'(got.status));
			if (got.source_address !== want.source_address)
				report_field("source_address", want.source_address, got.source_address);
			if (got.dest_address !== want.dest_address)
				report_field("dest_address", want.dest_address, got.dest_address);
			if (got.chunk_count !== want.chunk_count)
				report_field("chunk_count", 32'(want.chunk_count), 32'(got.chunk_count));
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	sg_walk_tracker tracker = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic long_hold_go = 1'b0;
	bit hold_taken = 0;
	logic [AddrBits-1:0] cur_dev = '0;

	dma_scatter_gather_chunk_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (long_hold_go && !hold_taken) begin
			hold_taken <= 1;
			hold_left <= LongHold;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Observe every handshake and feed the tracker.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			tracker.set_reg(cfg_index, cfg_data);
		if (in_valid && in_ready)
			tracker.note_request(in_data);
		if (out_valid && out_ready)
			tracker.check_result(out_data);
	end

	// Abort when no channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, tracker.pending());
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t make_req(cmd_e cmd, logic [AddrBits-1:0] addr,
			logic [CountBits-1:0] len, logic [CountBits-1:0] done);
		in_item_t r;
		r.command = cmd;
		r.entry_address = addr;
		r.entry_length = len;
		r.done_count = done;
		return r;
	endfunction

	function automatic in_item_t random_req();
		in_item_t r;
		r.command = 2'($urandom_range(3));
		r.entry_address = $urandom;
		r.entry_length = CountBits'($urandom);
		r.done_count = CountBits'($urandom);
		return r;
	endfunction

	function automatic logic [CountBits-1:0] pick_len();
		case ($urandom_range(9))
			0:       return '0;
			1, 2:    return CountBits'($urandom);
			default: return CountBits'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [CountBits-1:0] pick_done();
		case ($urandom_range(9))
			0:       return '0;
			1, 2, 3: return CountBits'($urandom);
			default: return CountBits'($urandom_range(1, 32));
		endcase
	endfunction

	function automatic logic [1:0] pick_mode();
		if ($urandom_range(9) < 8)
			return $urandom_range(1) ? MODE_MEM_TO_DEV : MODE_DEV_TO_MEM;
		return 2'($urandom_range(2, 3));
	endfunction

	function automatic int unsigned pick_entries();
		int unsigned r;
		r = $urandom_range(19);
		if (r < 14)
			return $urandom_range(1, 4);
		if (r < 18)
			return $urandom_range(5, MaxEntries - 1);
		return $urandom_range(MaxEntries, MaxEntries + 1);
	endfunction

	// Offer one request; valid stays high after acceptance unless the next call drops it.
	task automatic send_request(in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold the input until every expected result is back, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(logic [1:0] mode, logic [AddrBits-1:0] dev, bit claimed);
		write_reg(CFG_MODE, {30'($urandom), mode});
		write_reg(CFG_DEV_ADDR, dev);
		write_reg(CFG_CLAIMED, {31'($urandom), claimed});
		cfg_valid <= 1'b0;
		cur_dev = dev;
	endtask

	// Load a list, start it and feed chunk completions, with some noise mixed in.
	task automatic run_list(int unsigned n_entries);
		int unsigned steps;
		steps = 3 * n_entries + 3;
		for (int unsigned i = 0; i < n_entries; i++)
			send_request(make_req(CMD_LOAD, $urandom, pick_len(), CountBits'($urandom)));
		send_request(make_req(CMD_START, $urandom, CountBits'($urandom),
			CountBits'($urandom)));
		for (int unsigned i = 0; i < steps; i++) begin
			if (i == steps / 2 && $urandom_range(4) == 0) begin
				wait_idle();
				program_regs(pick_mode(), cur_dev, $urandom_range(9) != 0);
			end
			if ($urandom_range(99) < 6)
				send_request(random_req());
			else
				send_request(make_req(CMD_CHUNK, $urandom, CountBits'($urandom), pick_done()));
		end
	endtask

	initial begin
		int unsigned target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: nothing active, empty list, zero first length
		send_request(make_req(CMD_CHUNK, '0, '0, '0));
		send_request('1);
		send_request(make_req(CMD_START, '0, '0, '0));
		send_request(make_req(CMD_LOAD, '0, '0, '0));
		send_request(make_req(CMD_START, '0, '0, '0));

		// Unclaimed channel still writes the device side
		wait_idle();
		write_reg(CfgSpare, $urandom);
		program_regs(MODE_DEV_TO_MEM, '1, 0);
		send_request(make_req(CMD_LOAD, '1, '1, '1));
		send_request(make_req(CMD_START, '1, '1, '1));

		// Invalid mode
		wait_idle();
		program_regs(2'($urandom_range(2, 3)), '0, 1);
		send_request(make_req(CMD_LOAD, $urandom, 24'd10, '0));
		send_request(make_req(CMD_START, '0, '0, '0));

		// Address wrap, load refused while active, advance onto a zero-length entry
		wait_idle();
		program_regs(MODE_MEM_TO_DEV, 32'h1234_5678, 1);
		send_request(make_req(CMD_LOAD, 32'hFFFF_FFF0, 24'h20, '0));
		send_request(make_req(CMD_LOAD, 32'h0000_0100, '0, '0));
		send_request(make_req(CMD_LOAD, 32'h0000_0200, 24'd4, '0));
		send_request(make_req(CMD_START, '0, '0, '0));
		send_request(make_req(CMD_LOAD, $urandom, 24'd8, '0));
		send_request(make_req(CMD_CHUNK, '0, '0, 24'h10));
		send_request(make_req(CMD_CHUNK, '0, '0, '1));

		// Step to the next entry, switch mode mid-list, run off the end
		wait_idle();
		program_regs(MODE_DEV_TO_MEM, $urandom, 1);
		send_request(make_req(CMD_LOAD, 32'h0000_0040, 24'd8, '0));
		send_request(make_req(CMD_LOAD, 32'h0000_0080, 24'd8, '0));
		send_request(make_req(CMD_START, '0, '0, '0));
		send_request(make_req(CMD_CHUNK, '0, '0, 24'd8));
		send_request(make_req(CMD_CHUNK, '0, '0, 24'd3));
		wait_idle();
		program_regs(MODE_MEM_TO_DEV, cur_dev, 1);
		send_request(make_req(CMD_CHUNK, '0, '0, 24'd2));
		send_request(make_req(CMD_CHUNK, '0, '0, 24'd3));
		send_request(make_req(CMD_CHUNK, '0, '0, 24'd1));

		// Random lists under four pacing phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			target = items_sent + ItemsPerPhase;
			while (items_sent < target) begin
				wait_idle();
				program_regs(pick_mode(), ($urandom_range(7) == 0) ? '1 : $urandom,
					$urandom_range(9) != 0);
				// back-pressure the output while requests keep coming
				if (phase == 0)
					long_hold_go <= 1'b1;
				run_list(pick_entries());
			end
		end

		wait_idle();
		$display("Ran %0d requests over four pacing phases, %0d results checked, %0d mismatches",
			items_sent, tracker.results_seen, tracker.mismatches);
		$display("Status mix: ok %0d prog %0d fin %0d empty %0d zlen %0d mode %0d inact %0d full %0d",
			tracker.status_hits[ST_ACCEPTED], tracker.status_hits[ST_PROGRAMMED],
			tracker.status_hits[ST_FINISHED], tracker.status_hits[ST_EMPTY],
			tracker.status_hits[ST_ZERO_LEN], tracker.status_hits[ST_BAD_MODE],
			tracker.status_hits[ST_INACTIVE], tracker.status_hits[ST_FULL]);
		if (tracker.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/dsgcs_pkg.sv
rtl/dsgcs_ctrl.sv
rtl/dsgcs_dp.sv
rtl/dma_scatter_gather_chunk_sequencer.sv
rtl/dsgcs_checker.sv
verif/dma_scatter_gather_chunk_sequencer_tb.sv
